// ===== rtl/core/clex_pkg.sv =====
package clex_pkg;

	localparam int unsigned MAX_TOKEN_LEN = 255;
	localparam int unsigned LA_DEPTH      = 5;
	localparam int unsigned NUM_PAT       = 28;

	localparam logic [4:0] KIND_NUMBER = 5'd28;
	localparam logic [4:0] KIND_IDENT  = 5'd29;
	localparam logic [4:0] KIND_END    = 5'd30;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		RUN_NONE   = 2'd0,
		RUN_NUMBER = 2'd1,
		RUN_IDENT  = 2'd2
	} run_mode_t;

	typedef enum logic [1:0] {
		DEC_WAIT  = 2'd0,
		DEC_MATCH = 2'd1,
		DEC_NONE  = 2'd2
	} dec_status_t;

	typedef struct packed {
		dec_status_t status;
		logic [4:0]  idx;
	} dec_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [7:0]  length;
		logic [15:0] line;
		logic [15:0] col;
		logic [15:0] count;
		logic        is_end;
	} result_t;

	// Up to two results per source byte; res1 is used only with res0.
	typedef struct packed {
		logic    first;
		logic    second;
		result_t res0;
		result_t res1;
	} push_t;

	// Byte 0 of each entry is the first character of the pattern.
	localparam logic [LA_DEPTH-1:0][7:0] PAT_TEXT [NUM_PAT] = '{
		{CH_NUL, CH_NUL, "t", "n", "i"},
		{CH_NUL, "r", "a", "h", "c"},
		{CH_NUL, CH_NUL, CH_NUL, "+", "+"},
		{CH_NUL, CH_NUL, CH_NUL, "-", "-"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "+"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "-"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "*"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "|"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "&"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "/"},
		{CH_NUL, CH_NUL, CH_NUL, "=", "="},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "="},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "("},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, ")"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "{"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "}"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "["},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "]"},
		{CH_NUL, CH_NUL, CH_NUL, "=", ">"},
		{CH_NUL, CH_NUL, CH_NUL, "=", "<"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, ">"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, "<"},
		{CH_NUL, CH_NUL, CH_NUL, "=", "!"},
		{CH_NUL, CH_NUL, CH_NUL, "f", "i"},
		{CH_NUL, "e", "s", "l", "e"},
		{"e", "l", "i", "h", "w"},
		{CH_NUL, CH_NUL, "r", "o", "f"},
		{CH_NUL, CH_NUL, CH_NUL, CH_NUL, ";"}
	};

	localparam logic [2:0] PAT_LEN [NUM_PAT] = '{
		3'd3, 3'd4, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
		3'd1, 3'd1, 3'd2, 3'd2, 3'd4, 3'd5, 3'd3, 3'd1
	};

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic [15:0] sat_add16(input logic [15:0] x, input logic [7:0] a);
		logic [16:0] s;
		s = {1'b0, x} + {9'd0, a};
		return s[16] ? 16'hffff : s[15:0];
	endfunction

	// First pattern that agrees with the m held bytes wins; it either matches
	// in full or needs more bytes.
	function automatic dec_t decide(input logic [LA_DEPTH-1:0][7:0] w, input logic [2:0] m);
		dec_t d;
		logic agree;
		d.status = DEC_NONE;
		d.idx    = '0;
		for (int i = NUM_PAT - 1; i >= 0; i--) begin
			agree = 1'b1;
			for (int j = 0; j < LA_DEPTH; j++) begin
				if (3'(j) < m && 3'(j) < PAT_LEN[i] && w[j] != PAT_TEXT[i][j])
					agree = 1'b0;
			end
			if (agree) begin
				d.idx    = 5'(i);
				d.status = (m >= PAT_LEN[i]) ? DEC_MATCH : DEC_WAIT;
			end
		end
		return d;
	endfunction

endpackage

// ===== rtl/core/clex_core.sv =====
module clex_core #(
	parameter int unsigned MAX_TOKEN_LEN = clex_pkg::MAX_TOKEN_LEN
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      data,
	output clex_pkg::push_t push
);

	localparam logic [7:0] LEN_CAP = (MAX_TOKEN_LEN < 255) ? 8'(MAX_TOKEN_LEN) : 8'd255;

	typedef struct packed {
		logic                emit;
		clex_pkg::result_t   res;
		logic [15:0]         col;
		logic [15:0]         line;
		logic [15:0]         count;
		clex_pkg::run_mode_t run;
		logic                hold;
		logic                stop;
	} fresh_t;

	// Handle one byte at a token start with nothing held.
	function automatic fresh_t fresh(input logic [7:0] b, input logic [15:0] col,
			input logic [15:0] line, input logic [15:0] count);
		fresh_t f;
		clex_pkg::dec_t d;
		logic [clex_pkg::LA_DEPTH-1:0][7:0] w;
		w       = '0;
		w[0]    = b;
		d       = clex_pkg::decide(w, 3'd1);
		f       = '0;
		f.col   = col;
		f.line  = line;
		f.count = count;
		f.run   = clex_pkg::RUN_NONE;
		if (clex_pkg::is_space(b)) begin
			if (b == clex_pkg::CH_NL) begin
				f.line = clex_pkg::sat_add16(line, 8'd1);
				f.col  = 16'd1;
			end else begin
				f.col = clex_pkg::sat_add16(col, 8'd1);
			end
		end else if (d.status == clex_pkg::DEC_WAIT) begin
			f.hold = 1'b1;
		end else if (d.status == clex_pkg::DEC_MATCH) begin
			f.emit  = 1'b1;
			f.col   = clex_pkg::sat_add16(col, {5'd0, clex_pkg::PAT_LEN[d.idx]});
			f.count = clex_pkg::sat_add16(count, 8'd1);
			f.res   = '{kind: d.idx, length: {5'd0, clex_pkg::PAT_LEN[d.idx]}, line: line,
				col: f.col, count: f.count, is_end: 1'b0};
		end else if (clex_pkg::is_digit(b)) begin
			f.run = clex_pkg::RUN_NUMBER;
			f.col = clex_pkg::sat_add16(col, 8'd1);
		end else if (clex_pkg::is_word(b)) begin
			f.run = clex_pkg::RUN_IDENT;
			f.col = clex_pkg::sat_add16(col, 8'd1);
		end else begin
			f.emit = 1'b1;
			f.stop = 1'b1;
			f.res  = '{kind: clex_pkg::KIND_END, length: 8'd0, line: line, col: col,
				count: count, is_end: 1'b1};
		end
		return f;
	endfunction

	logic [clex_pkg::LA_DEPTH-2:0][7:0] la_q, la_n;
	logic [2:0]          fill_q, fill_n;
	clex_pkg::run_mode_t run_q, run_n;
	logic [7:0]          run_len_q, run_len_n;
	logic [15:0]         line_q, line_n;
	logic [15:0]         col_q, col_n;
	logic [15:0]         count_q, count_n;
	logic                stop_q, stop_n;

	logic [clex_pkg::LA_DEPTH-1:0][7:0] win;
	logic [2:0]          win_len;
	clex_pkg::dec_t      dec;
	logic [2:0]          pat_len;
	logic [15:0]         cnt_inc;
	logic [7:0]          fr_adv;
	logic [15:0]         fr_col;
	logic [15:0]         fr_count;
	fresh_t              fr;
	logic                cont;
	logic                use_fresh;

	// Held bytes plus the new byte form the match window.
	always_comb begin
		win = '0;
		for (int j = 0; j < clex_pkg::LA_DEPTH - 1; j++) begin
			if (3'(j) < fill_q)
				win[j] = la_q[j];
		end
		win[fill_q] = data;
	end

	assign win_len = fill_q + 3'd1;
	assign dec     = clex_pkg::decide(win, win_len);
	assign pat_len = clex_pkg::PAT_LEN[dec.idx];
	assign cnt_inc = clex_pkg::sat_add16(count_q, 8'd1);
	assign cont    = (run_q == clex_pkg::RUN_NUMBER) ? clex_pkg::is_digit(data)
		: clex_pkg::is_word(data);

	// Column and count as they stand when the new byte is looked at on its own.
	always_comb begin
		if (run_q != clex_pkg::RUN_NONE || fill_q == 3'd0)
			fr_adv = 8'd0;
		else if (dec.status == clex_pkg::DEC_MATCH)
			fr_adv = {5'd0, pat_len};
		else
			fr_adv = {5'd0, fill_q};
	end

	assign fr_col   = clex_pkg::sat_add16(col_q, fr_adv);
	assign fr_count = (run_q != clex_pkg::RUN_NONE || fill_q != 3'd0) ? cnt_inc : count_q;
	assign fr       = fresh(data, fr_col, line_q, fr_count);

	always_comb begin
		la_n      = la_q;
		fill_n    = fill_q;
		run_n     = run_q;
		run_len_n = run_len_q;
		line_n    = line_q;
		col_n     = col_q;
		count_n   = count_q;
		stop_n    = stop_q;
		push      = '0;
		use_fresh = 1'b0;
		if (step && !stop_q) begin
			if (run_q != clex_pkg::RUN_NONE) begin
				if (cont) begin
					if (run_len_q < LEN_CAP)
						run_len_n = run_len_q + 8'd1;
					col_n = clex_pkg::sat_add16(col_q, 8'd1);
				end else begin
					push.first = 1'b1;
					push.res0  = '{kind: (run_q == clex_pkg::RUN_NUMBER) ? clex_pkg::KIND_NUMBER
						: clex_pkg::KIND_IDENT, length: run_len_q, line: line_q, col: col_q,
						count: cnt_inc, is_end: 1'b0};
					run_n     = clex_pkg::RUN_NONE;
					run_len_n = 8'd0;
					use_fresh = 1'b1;
				end
			end else if (fill_q == 3'd0) begin
				use_fresh = 1'b1;
			end else begin
				case (dec.status)
					clex_pkg::DEC_WAIT: begin
						la_n[fill_q[1:0]] = data;
						fill_n            = win_len;
					end
					clex_pkg::DEC_MATCH: begin
						push.first = 1'b1;
						push.res0  = '{kind: dec.idx, length: {5'd0, pat_len}, line: line_q,
							col: fr_col, count: cnt_inc, is_end: 1'b0};
						fill_n  = 3'd0;
						col_n   = fr_col;
						count_n = cnt_inc;
						// a one-character fallback leaves the new byte unread
						if (pat_len < win_len)
							use_fresh = 1'b1;
					end
					clex_pkg::DEC_NONE: begin
						fill_n = 3'd0;
						if (clex_pkg::is_word(la_q[0])) begin
							if (clex_pkg::is_word(data)) begin
								run_n     = clex_pkg::RUN_IDENT;
								run_len_n = {5'd0, win_len};
								col_n     = clex_pkg::sat_add16(col_q, {5'd0, win_len});
							end else begin
								push.first = 1'b1;
								push.res0  = '{kind: clex_pkg::KIND_IDENT, length: {5'd0, fill_q},
									line: line_q, col: fr_col, count: cnt_inc, is_end: 1'b0};
								col_n     = fr_col;
								count_n   = cnt_inc;
								use_fresh = 1'b1;
							end
						end else begin
							push.first = 1'b1;
							push.res0  = '{kind: clex_pkg::KIND_END, length: 8'd0, line: line_q,
								col: col_q, count: count_q, is_end: 1'b1};
							stop_n = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			if (use_fresh) begin
				col_n   = fr.col;
				line_n  = fr.line;
				count_n = fr.count;
				if (fr.run != clex_pkg::RUN_NONE) begin
					run_n     = fr.run;
					run_len_n = 8'd1;
				end
				if (fr.hold) begin
					la_n[0] = data;
					fill_n  = 3'd1;
				end
				if (fr.stop)
					stop_n = 1'b1;
				if (fr.emit) begin
					if (push.first) begin
						push.second = 1'b1;
						push.res1   = fr.res;
					end else begin
						push.first = 1'b1;
						push.res0  = fr.res;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= 3'd0;
			run_q     <= clex_pkg::RUN_NONE;
			run_len_q <= 8'd0;
			line_q    <= 16'd0;
			col_q     <= 16'd0;
			count_q   <= 16'd0;
			stop_q    <= 1'b0;
		end else begin
			fill_q    <= fill_n;
			run_q     <= run_n;
			run_len_q <= run_len_n;
			line_q    <= line_n;
			col_q     <= col_n;
			count_q   <= count_n;
			stop_q    <= stop_n;
		end
	end

	always_ff @(posedge clk) begin
		la_q <= la_n;
	end

endmodule

// ===== rtl/core/c_subset_lexer.sv =====
// Channel  Direction  Handshake             Payload
// src      in         src_valid/src_stall   source_byte
// tok      out        tok_valid/tok_stall   token_kind, token_length, line_number,
//                                           end_column, token_count, is_end
//
// One source byte per cycle while src_stall is low. A request is registered,
// then resolved by the tokenizer core when the queue has room; the core writes
// zero, one or two results into a four-entry result queue, whose head shows on
// tok. The queue drains one result per cycle while tok_stall is low, and the
// input waits on queue space, since a byte that closes two tokens takes two.
// arst_n clears the tokenizer state and the queue; there is no clearing pass.
// src_stall rises when the input register holds a byte and the queue lacks two
// free entries (a pop in that cycle frees one); tok_stall holds the queue head.
module c_subset_lexer #(
	parameter int unsigned MAX_TOKEN_LEN = clex_pkg::MAX_TOKEN_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        src_valid,
	output logic        src_stall,
	input  logic [7:0]  source_byte,
	output logic        tok_valid,
	input  logic        tok_stall,
	output logic [4:0]  token_kind,
	output logic [7:0]  token_length,
	output logic [15:0] line_number,
	output logic [15:0] end_column,
	output logic [15:0] token_count,
	output logic        is_end
);

	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned PTR_W     = $clog2(OUT_DEPTH);

	logic [7:0]        byte_s1;
	logic              valid_s1;
	logic              go;
	logic              pop;
	clex_pkg::push_t   push;

	clex_pkg::result_t res_q [OUT_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W:0]    count_q;
	logic [PTR_W:0]    n_push;

	// Resolve the held byte only when the queue can take two results.
	assign pop       = tok_valid && !tok_stall;
	assign go        = valid_s1 && ((count_q <= (PTR_W+1)'(OUT_DEPTH - 2))
		|| (pop && count_q <= (PTR_W+1)'(OUT_DEPTH - 1)));
	assign src_stall = valid_s1 && !go;

	// Hold the request until the core takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall)
			byte_s1 <= source_byte;
	end

	clex_core #(
		.MAX_TOKEN_LEN(MAX_TOKEN_LEN)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (go),
		.data  (byte_s1),
		.push  (push)
	);

	assign n_push = (PTR_W+1)'(push.first) + (PTR_W+1)'(push.second);

	// Result queue: advance write pointer by the number of results pushed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[PTR_W-1:0];
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + n_push - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.first)
			res_q[wr_ptr_q] <= push.res0;
		if (push.second)
			res_q[wr_ptr_q + 1'b1] <= push.res1;
	end

	assign tok_valid    = (count_q != '0);
	assign token_kind   = res_q[rd_ptr_q].kind;
	assign token_length = res_q[rd_ptr_q].length;
	assign line_number  = res_q[rd_ptr_q].line;
	assign end_column   = res_q[rd_ptr_q].col;
	assign token_count  = res_q[rd_ptr_q].count;
	assign is_end       = res_q[rd_ptr_q].is_end;

endmodule

// ===== rtl/core/clex_checker.sv =====
module clex_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        src_valid,
	input logic        src_stall,
	input logic [7:0]  source_byte,
	input logic        tok_valid,
	input logic        tok_stall,
	input logic [4:0]  token_kind,
	input logic [7:0]  token_length,
	input logic [15:0] line_number,
	input logic [15:0] end_column,
	input logic [15:0] token_count,
	input logic        is_end
);

	logic        pop;
	logic [15:0] seen_q;
	logic        end_seen_q;

	assign pop = tok_valid && !tok_stall;

	// Track the last token count delivered and whether the end has gone out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= 16'd0;
			end_seen_q <= 1'b0;
		end else if (pop) begin
			if (is_end)
				end_seen_q <= 1'b1;
			else
				seen_q <= token_count;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_stall |=> tok_valid && $stable(token_kind) && $stable(token_length)
			&& $stable(line_number) && $stable(end_column) && $stable(token_count)
			&& $stable(is_end))
		else $error("result changed while stalled");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !is_end |-> token_count == ((seen_q == 16'hffff) ? seen_q : seen_q + 16'd1))
		else $error("token count out of sequence");

	a_end_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && is_end |-> token_count == seen_q && token_kind == clex_pkg::KIND_END
			&& token_length == 8'd0)
		else $error("end item malformed");

	a_token_form: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !is_end |-> token_length != 8'd0 && token_kind != clex_pkg::KIND_END)
		else $error("token with empty length or end kind");

	a_quiet_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		end_seen_q |-> !tok_valid)
		else $error("result after end of stream");

endmodule

bind c_subset_lexer clex_checker u_chk (.*);
